### sv/smc_pkg.sv
// Shared types and constants for the soil moisture conditioner.
`timescale 1ns / 1ps
package smc_pkg;

    localparam int CHANNELS     = 4;
    localparam int CH_W         = 2;
    localparam int RAW_W        = 12;
    localparam int WT_W         = 7;
    localparam int PCT_W        = 7;
    localparam int CNT_W        = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int FULL_SCALE   = 100;
    localparam int RANGE_MARGIN = 600;
    localparam int PROD_W       = RAW_W + WT_W;
    localparam int DIVD_W       = PROD_W;
    localparam int DIVS_W       = RAW_W;

    // Divide a blend sum by 100 as (sum * RECIP_100) >> RECIP_SHIFT; exact for sums below 2^19.
    localparam int RECIP_SHIFT  = 26;
    localparam int RECIP_W      = 20;
    localparam int SCALED_W     = PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_100 = 20'd671089;

    localparam int DRY_RESET    = 3000;
    localparam int WET_RESET    = 1200;
    localparam int WT_RESET     = 30;

    typedef enum logic [1:0] {
        HEALTH_OK           = 2'd0,
        HEALTH_OUT_OF_RANGE = 2'd1,
        HEALTH_READ_FAILED  = 2'd2
    } t_health;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DRY    = 2'd0,
        REG_WET    = 2'd1,
        REG_WEIGHT = 2'd2
    } t_cfg_idx;

    // Request to the divider.
    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } t_div_req;

endpackage

### sv/soil_moisture_conditioner.sv
// Sequence: a failed read goes from the accepted beat straight to the output register; a
// sample taken outright goes through the percentage multiply and the bit-serial divider
// (19 steps), and a blended one first through the two blend multiplies and the reciprocal
// scale. Equal references skip the divider. Throughput: one beat at a time; the next beat is
// taken the cycle after the result is loaded, which waits while the full output register waits on m_tready.
// Reset: synchronous, active low; clears per-channel stores, loads the calibration defaults.
`timescale 1ns / 1ps
module soil_moisture_conditioner (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [smc_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [smc_pkg::RAW_W-1:0]        i_cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,  // [11:0] raw_sample
    input  logic [2:0]                       s_tuser,  // [1:0] channel, [2] read_failed
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [11:0] raw_out, [23:12] filtered_level, [30:24] moisture_percent, [62:31] samples_taken
    output logic [63:0]                      m_tdata,
    // [1:0] channel_out, [3:2] health, [4] reading_valid
    output logic [4:0]                       m_tuser
);
    import smc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_SCALE_F,
        ST_MUL_P,
        ST_DIV_P,
        ST_OUT
    } t_state;

    t_state              r_state;
    logic [RAW_W-1:0]    r_dry;
    logic [RAW_W-1:0]    r_wet;
    logic [WT_W-1:0]     r_wt;

    logic [RAW_W-1:0]    r_avg  [CHANNELS];
    logic [PCT_W-1:0]    r_moist[CHANNELS];
    logic [CNT_W-1:0]    r_count[CHANNELS];

    logic [CH_W-1:0]     r_ch;
    logic [RAW_W-1:0]    r_raw;
    logic                r_failed;
    t_health             r_health;
    logic [CNT_W-1:0]    r_cnt;
    logic [RAW_W-1:0]    r_filt;
    logic [PCT_W-1:0]    r_pct;
    logic [PROD_W-1:0]   r_acc;
    logic [DIVS_W-1:0]   r_divisor;
    logic                r_div_start;
    logic                r_neg;

    logic                r_m_valid;
    logic [63:0]         r_m_data;
    logic [4:0]          r_m_user;

    logic [CH_W-1:0]     in_ch;
    logic [RAW_W-1:0]    in_raw;
    logic                in_failed;
    logic [CNT_W-1:0]    cnt_next;
    logic                take_raw;
    logic                in_low;
    logic                in_high;
    logic [WT_W-1:0]     wt_sat;
    logic [RAW_W-1:0]    mul_x;
    logic [WT_W-1:0]     mul_y;
    logic [PROD_W-1:0]   prod;
    logic [SCALED_W-1:0] scaled;
    logic [RAW_W:0]      diff;
    logic [RAW_W:0]      den;
    logic [RAW_W-1:0]    diff_mag;
    logic [RAW_W-1:0]    den_mag;
    t_div_req            div_req;
    logic                div_done;
    logic [DIVD_W-1:0]   div_quo;

    assign in_ch     = s_tuser[CH_W-1:0];
    assign in_failed = s_tuser[CH_W];
    assign in_raw    = s_tdata[RAW_W-1:0];
    assign cnt_next  = r_count[in_ch] + CNT_W'(1);

    // take the sample outright on a channel's first sample or while its level is zero
    assign take_raw = (cnt_next == CNT_W'(1)) || (r_avg[in_ch] == '0);

    // window widened by the margin on both sides, kept in unsigned 14-bit math
    assign in_low  = ({2'b00, in_raw} + 14'(RANGE_MARGIN)) < {2'b00, r_wet};
    assign in_high = {2'b00, in_raw} > ({2'b00, r_dry} + 14'(RANGE_MARGIN));

    assign wt_sat = (r_wt > WT_W'(FULL_SCALE)) ? WT_W'(FULL_SCALE) : r_wt;

    assign diff     = {1'b0, r_dry} - {1'b0, r_filt};
    assign den      = {1'b0, r_dry} - {1'b0, r_wet};
    assign diff_mag = diff[RAW_W] ? RAW_W'(-diff) : diff[RAW_W-1:0];
    assign den_mag  = den[RAW_W]  ? RAW_W'(-den)  : den[RAW_W-1:0];

    // shared multiplier operand selection
    always_comb begin
        case (r_state)
            ST_MUL_A: begin
                mul_x = r_filt;
                mul_y = WT_W'(FULL_SCALE) - wt_sat;
            end
            ST_MUL_B: begin
                mul_x = r_raw;
                mul_y = wt_sat;
            end
            ST_MUL_P: begin
                mul_x = diff_mag;
                mul_y = WT_W'(FULL_SCALE);
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    assign prod = PROD_W'(mul_x) * PROD_W'(mul_y);

    // blend sum divided by 100 through the reciprocal
    assign scaled = SCALED_W'(r_acc) * SCALED_W'(RECIP_100);

    assign div_req.start    = r_div_start;
    assign div_req.dividend = r_acc;
    assign div_req.divisor  = r_divisor;

    smc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_dry       <= RAW_W'(DRY_RESET);
            r_wet       <= RAW_W'(WET_RESET);
            r_wt        <= WT_W'(WT_RESET);
            r_div_start <= 1'b0;
            r_m_valid   <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_avg[i]   <= '0;
                r_moist[i] <= '0;
                r_count[i] <= '0;
            end
        end else begin
            r_div_start <= (r_state == ST_MUL_P) && (den != '0);
            if (r_m_valid && m_tready && (r_state != ST_OUT)) begin
                r_m_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_DRY:    r_dry <= i_cfg_wdata;
                    REG_WET:    r_wet <= i_cfg_wdata;
                    REG_WEIGHT: r_wt  <= i_cfg_wdata[WT_W-1:0];
                    default:    ;
                endcase
            end

            case (r_state)
                ST_IDLE: begin
                    // drop a beat for a channel beyond the store depth
                    if (s_tvalid && ({1'b0, in_ch} < (CH_W+1)'(CHANNELS))) begin
                        r_ch             <= in_ch;
                        r_raw            <= in_raw;
                        r_failed         <= in_failed;
                        r_cnt            <= cnt_next;
                        r_count[in_ch]   <= cnt_next;
                        r_filt           <= (!in_failed && take_raw) ? in_raw : r_avg[in_ch];
                        r_pct            <= r_moist[in_ch];
                        if (in_failed) begin
                            r_health <= HEALTH_READ_FAILED;
                            r_state  <= ST_OUT;
                        end else begin
                            r_health <= (in_low || in_high) ? HEALTH_OUT_OF_RANGE : HEALTH_OK;
                            r_state  <= take_raw ? ST_MUL_P : ST_MUL_A;
                        end
                    end
                end
                ST_MUL_A: begin
                    r_acc   <= prod;
                    r_state <= ST_MUL_B;
                end
                ST_MUL_B: begin
                    r_acc   <= r_acc + prod;
                    r_state <= ST_SCALE_F;
                end
                ST_SCALE_F: begin
                    r_filt  <= scaled[RECIP_SHIFT +: RAW_W];
                    r_state <= ST_MUL_P;
                end
                ST_MUL_P: begin
                    r_acc     <= prod;
                    r_neg     <= diff[RAW_W] ^ den[RAW_W];
                    r_divisor <= den_mag;
                    if (den == '0) begin
                        r_pct   <= '0;
                        r_state <= ST_OUT;
                    end else begin
                        r_state <= ST_DIV_P;
                    end
                end
                ST_DIV_P: begin
                    if (div_done) begin
                        // a negative quotient clamps to zero, a large one to full scale
                        if (r_neg) begin
                            r_pct <= '0;
                        end else if (div_quo > DIVD_W'(FULL_SCALE)) begin
                            r_pct <= PCT_W'(FULL_SCALE);
                        end else begin
                            r_pct <= div_quo[PCT_W-1:0];
                        end
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_m_valid || m_tready) begin
                        if (!r_failed) begin
                            r_avg[r_ch]   <= r_filt;
                            r_moist[r_ch] <= r_pct;
                        end
                        r_m_valid <= 1'b1;
                        r_m_data  <= {1'b0, r_cnt, r_pct, r_filt, r_raw};
                        r_m_user  <= {(r_health == HEALTH_OK), r_health, r_ch};
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (r_state == ST_IDLE);
    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;
    assign m_tuser  = r_m_user;

endmodule

### sv/smc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module smc_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  smc_pkg::t_div_req              i_req,
    output logic                           o_done,
    output logic [smc_pkg::DIVD_W-1:0]     o_quotient
);
    import smc_pkg::*;

    localparam int STEP_W = $clog2(DIVD_W);

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_step;
    logic [DIVS_W-1:0]   r_rem;
    logic [DIVD_W-1:0]   r_quo;
    logic [DIVS_W-1:0]   r_dvs;
    logic [DIVS_W:0]     shifted;
    logic [DIVS_W:0]     trial;

    assign shifted = {r_rem, r_quo[DIVD_W-1]};
    assign trial   = shifted - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                // keep the partial remainder below the divisor
                if (!trial[DIVS_W]) begin
                    r_rem <= trial[DIVS_W-1:0];
                    r_quo <= {r_quo[DIVD_W-2:0], 1'b1};
                end else begin
                    r_rem <= shifted[DIVS_W-1:0];
                    r_quo <= {r_quo[DIVD_W-2:0], 1'b0};
                end
                if (r_step == STEP_W'(DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + STEP_W'(1);
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### sv/smc_checker.sv
// Port-level checks for the soil moisture conditioner, bound to the top level.
`timescale 1ns / 1ps
module smc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [4:0]  m_tuser
);
    import smc_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // one sample in flight: busy right after a beat is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again while a sample is in flight");

    a_valid_means_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tuser[4] == (m_tuser[3:2] == HEALTH_OK)))
        else $error("reading_valid disagrees with health");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[30:24] <= 7'(FULL_SCALE)))
        else $error("moisture percentage above full scale");

    a_health_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser[3:2] == HEALTH_READ_FAILED) |-> !m_tuser[4])
        else $error("failed read flagged as valid");

endmodule

bind soil_moisture_conditioner smc_checker u_smc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### tb/sv/soil_moisture_conditioner_tb.sv
// Self-checking testbench for the soil moisture conditioner stream block.
`timescale 1ns / 1ps
module soil_moisture_conditioner_tb;
    import smc_pkg::*;

    // Index with no register behind it; writes to it must leave the calibration alone.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int RANDOM_SAMPLES = 850;

    typedef struct {
        logic [CH_W-1:0]  channel;
        logic [RAW_W-1:0] raw;
        logic [RAW_W-1:0] level;
        logic [PCT_W-1:0] percent;
        t_health          health;
        logic             valid;
        logic [CNT_W-1:0] count;
    } t_moisture_reading;

    class moisture_scoreboard;
        logic [RAW_W-1:0] dry_ref;
        logic [RAW_W-1:0] wet_ref;
        logic [WT_W-1:0]  weight_pct;
        logic [RAW_W-1:0] level_mem [CHANNELS];
        logic [PCT_W-1:0] percent_mem [CHANNELS];
        logic [CNT_W-1:0] count_mem [CHANNELS];
        t_moisture_reading pending_readings [$];
        int errors;

        function new();
            dry_ref    = RAW_W'(DRY_RESET);
            wet_ref    = RAW_W'(WET_RESET);
            weight_pct = WT_W'(WT_RESET);
            for (int i = 0; i < CHANNELS; i++) begin
                level_mem[i]   = '0;
                percent_mem[i] = '0;
                count_mem[i]   = '0;
            end
            errors = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [RAW_W-1:0] value);
            case (idx)
                REG_DRY:    dry_ref = value;
                REG_WET:    wet_ref = value;
                REG_WEIGHT: weight_pct = value[WT_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [PCT_W-1:0] percent_of(logic [RAW_W-1:0] level);
            int span;
            int scaled;
            int q;
            span = int'(dry_ref) - int'(wet_ref);
            if (span == 0)
                return '0;
            scaled = (int'(dry_ref) - int'(level)) * FULL_SCALE;
            q = scaled / span;
            if (q < 0)
                q = 0;
            if (q > FULL_SCALE)
                q = FULL_SCALE;
            return q[PCT_W-1:0];
        endfunction

        function void predict_sample(logic [CH_W-1:0] ch, logic [RAW_W-1:0] raw,
                                     logic failed);
            t_moisture_reading r;
            int w;
            int blended;
            count_mem[ch] = count_mem[ch] + 1;
            r.valid = 1'b0;
            if (failed) begin
                r.health = HEALTH_READ_FAILED;
            end else begin
                w = (weight_pct > 100) ? 100 : int'(weight_pct);
                // take the sample outright on a first sample or an empty average
                if (count_mem[ch] == 1 || level_mem[ch] == 0)
                    blended = int'(raw);
                else
                    blended = (int'(level_mem[ch]) * (FULL_SCALE - w) + int'(raw) * w)
                              / FULL_SCALE;
                level_mem[ch]   = blended[RAW_W-1:0];
                percent_mem[ch] = percent_of(level_mem[ch]);
                if (int'(raw) < int'(wet_ref) - RANGE_MARGIN ||
                    int'(raw) > int'(dry_ref) + RANGE_MARGIN)
                    r.health = HEALTH_OUT_OF_RANGE;
                else
                    r.health = HEALTH_OK;
                r.valid = (r.health == HEALTH_OK);
            end
            r.channel = ch;
            r.raw     = raw;
            r.level   = level_mem[ch];
            r.percent = percent_mem[ch];
            r.count   = count_mem[ch];
            pending_readings.push_back(r);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void compare_result(logic [63:0] data, logic [4:0] user);
            t_moisture_reading want;
            if (pending_readings.size() == 0) begin
                $error("result with no reading pending: tdata %h tuser %h", data, user);
                errors++;
                return;
            end
            want = pending_readings.pop_front();
            check_field("channel_out", want.channel, user[1:0]);
            check_field("raw_out", want.raw, data[11:0]);
            check_field("filtered_level", want.level, data[23:12]);
            check_field("moisture_percent", want.percent, data[30:24]);
            check_field("samples_taken", want.count, data[62:31]);
            check_field("health", want.health, user[3:2]);
            check_field("reading_valid", want.valid, user[4]);
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_addr;
    logic [RAW_W-1:0]     i_cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;  // [11:0] raw_sample
    logic [2:0]           s_tuser;  // [1:0] channel, [2] read_failed
    logic                 m_tvalid;
    logic                 m_tready;
    // [11:0] raw_out, [23:12] filtered_level, [30:24] moisture_percent, [62:31] samples_taken
    logic [63:0]          m_tdata;
    logic [4:0]           m_tuser;  // [1:0] channel_out, [3:2] health, [4] reading_valid

    logic                 rx_stalls;
    int                   rx_left;

    moisture_scoreboard sb = new();

    soil_moisture_conditioner dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_tvalid && s_tready)
            sb.predict_sample(s_tuser[1:0], s_tdata[11:0], s_tuser[2]);
        if (i_rst_n && m_tvalid && m_tready)
            sb.compare_result(m_tdata, m_tuser);
    end

    // Receiver: alternate ready runs and stalls of random length when stalls are enabled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            rx_left  <= 0;
        end else if (!rx_stalls) begin
            m_tready <= 1'b1;
        end else if (rx_left == 0) begin
            m_tready <= !m_tready;
            rx_left  <= m_tready ? $urandom_range(1, 24) : $urandom_range(0, 6);
        end else begin
            rx_left <= rx_left - 1;
        end
    end

    task automatic send_sample(input logic [CH_W-1:0] ch, input logic [RAW_W-1:0] raw,
                               input logic failed);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, raw};
        s_tuser  <= {failed, ch};
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic pause_input(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        do @(posedge i_clk); while (sb.pending_readings.size() != 0);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [RAW_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.write_register(idx, value);
    endtask

    task automatic load_calibration(input logic [RAW_W-1:0] dry, input logic [RAW_W-1:0] wet,
                                    input logic [RAW_W-1:0] weight_word,
                                    input logic touch_spare);
        s_tvalid <= 1'b0;
        wait_idle();
        write_cfg(REG_DRY, dry);
        write_cfg(REG_WET, wet);
        write_cfg(REG_WEIGHT, weight_word);
        if (touch_spare)
            write_cfg(CFG_SPARE, RAW_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int sent;
        int phase_len;
        int burst;
        bit gap_free;
        int dry;
        int wet;
        int weight_word;
        int lo_edge;
        int hi_edge;
        logic [RAW_W-1:0] raw;

        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_addr  <= REG_DRY;
        i_cfg_wdata <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= '0;
        rx_stalls   <= 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default calibration: window 600..3600.
        send_sample(2'd0, 12'd2100, 1'b0);
        send_sample(2'd0, 12'd2400, 1'b0);
        send_sample(2'd0, 12'd4095, 1'b1);
        send_sample(2'd0, 12'd0, 1'b0);
        send_sample(2'd1, 12'd4095, 1'b0);
        send_sample(2'd1, 12'd0, 1'b0);
        // failed first read leaves the average empty, so the next good one is taken outright
        send_sample(2'd2, 12'd4095, 1'b1);
        send_sample(2'd2, 12'd1500, 1'b0);
        send_sample(2'd3, 12'd600, 1'b0);
        send_sample(2'd3, 12'd599, 1'b0);
        send_sample(2'd3, 12'd3600, 1'b0);
        send_sample(2'd3, 12'd3601, 1'b0);
        send_sample(2'd1, 12'd1200, 1'b0);

        // Equal references give zero percent.
        load_calibration(12'd2000, 12'd2000, 12'd100, 1'b1);
        send_sample(2'd0, 12'd1000, 1'b0);
        send_sample(2'd1, 12'd3000, 1'b0);
        send_sample(2'd2, 12'd2000, 1'b0);

        // Inverted full-scale references, weight above hundred saturates.
        load_calibration(12'd0, 12'd4095, 12'd127, 1'b0);
        send_sample(2'd0, 12'd0, 1'b0);
        send_sample(2'd3, 12'd4095, 1'b0);

        // Full-scale references, zero weight holds the average.
        load_calibration(12'd4095, 12'd0, 12'd0, 1'b1);
        send_sample(2'd0, 12'd4095, 1'b0);
        send_sample(2'd1, 12'd0, 1'b0);
        send_sample(2'd2, 12'd0, 1'b0);
        send_sample(2'd2, 12'd2048, 1'b0);

        sent = 0;
        while (sent < RANDOM_SAMPLES) begin
            case ($urandom_range(0, 9))
                0: begin dry = 4095; wet = 0; weight_word = 100; end
                1: begin dry = 0; wet = 4095; weight_word = 0; end
                2: begin
                    dry = $urandom_range(0, 4095);
                    wet = dry;
                    weight_word = $urandom_range(0, 127);
                end
                3: begin
                    dry = $urandom_range(0, 2000);
                    wet = $urandom_range(dry, 4095);
                    weight_word = $urandom_range(0, 100);
                end
                default: begin
                    wet = $urandom_range(0, 2500);
                    dry = $urandom_range(wet + 1, 4095);
                    weight_word = ($urandom_range(0, 4) == 0) ? $urandom_range(101, 127)
                                                              : $urandom_range(0, 100);
                end
            endcase
            // upper bits of the weight write are don't-care
            if ($urandom_range(0, 3) == 0)
                weight_word = weight_word | ($urandom_range(0, 31) << WT_W);
            load_calibration(RAW_W'(dry), RAW_W'(wet), RAW_W'(weight_word),
                             $urandom_range(0, 3) == 0);

            rx_stalls <= ($urandom_range(0, 3) != 0);
            gap_free  = ($urandom_range(0, 4) == 0);
            phase_len = $urandom_range(60, 140);
            if (phase_len > RANDOM_SAMPLES - sent)
                phase_len = RANDOM_SAMPLES - sent;
            lo_edge = ((dry < wet ? dry : wet) > 700) ? (dry < wet ? dry : wet) - 700 : 0;
            hi_edge = ((dry > wet ? dry : wet) < 3395) ? (dry > wet ? dry : wet) + 700 : 4095;

            while (phase_len > 0) begin
                burst = gap_free ? phase_len : $urandom_range(1, 16);
                if (burst > phase_len)
                    burst = phase_len;
                repeat (burst) begin
                    if ($urandom_range(0, 3) == 0)
                        raw = RAW_W'($urandom_range(0, 4095));
                    else
                        raw = RAW_W'($urandom_range(lo_edge, hi_edge));
                    send_sample(CH_W'($urandom_range(0, CHANNELS - 1)), raw,
                                $urandom_range(0, 9) == 0);
                end
                phase_len -= burst;
                sent += burst;
                if (!gap_free && phase_len > 0)
                    pause_input($urandom_range(1, 8));
            end
        end

        s_tvalid <= 1'b0;
        wait_idle();
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_readings.size() == 0)
            $display("soil_moisture_conditioner_tb: PASS");
        else
            $display("soil_moisture_conditioner_tb: FAIL");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("soil_moisture_conditioner_tb: FAIL");
        $finish;
    end

endmodule
